/* design/bsu_pkg.sv */
// ----------------------------------------------------------------------------
// bsu_pkg: shared types and constants for the bucket sort unit
// Sizes of the item store, queue entry layout and back-end states.
// ----------------------------------------------------------------------------
package bsu_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_BITS  = 16;
   localparam int IDX_BITS    = $clog2(MAX_ITEMS);
   localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
   localparam int CFG_BITS    = 7;
   localparam int KEY_BITS    = IDX_BITS + VALUE_BITS;
   localparam int Q_DEPTH     = 4;
   localparam int Q_IDX_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);

   // one classified transaction on its way from front to back
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]   bucket;
      logic                  last;
   } entry_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } back_state_type;

endpackage

/* design/bsu_ram.sv */
// ----------------------------------------------------------------------------
// bsu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/bsu_front.sv */
// ----------------------------------------------------------------------------
// bsu_front: accept and classify input transactions
// Holds the bucket count register and computes each value's bucket.
// ----------------------------------------------------------------------------
module bsu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bsu_pkg::CFG_BITS-1:0]  csr_wdata,
   input  logic                          req_valid,
   input  logic [bsu_pkg::VALUE_BITS-1:0] req_value,
   input  logic                          req_last,
   output logic                          req_stall,
   input  bsu_pkg::q_status_type         q_status,
   output logic                          push,
   output bsu_pkg::entry_type            push_entry
);
   import bsu_pkg::*;

   localparam int PROD_BITS = CNT_BITS + VALUE_BITS;

   logic [CFG_BITS-1:0]  count_ff;
   logic [CFG_BITS-1:0]  count_in;
   logic [CNT_BITS-1:0]  buckets;
   logic [PROD_BITS-1:0] product;
   logic [CNT_BITS-1:0]  bk_raw;
   logic [CNT_BITS-1:0]  bk_clamp;

   // write the bucket count register
   always_comb begin
      count_in = count_ff;
      if (csr_we) begin
         count_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CFG_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // limit the bucket count to one through the store size
   always_comb begin
      if (count_ff == '0) begin
         buckets = CNT_BITS'(1);
      end else if (CNT_BITS'(count_ff) > CNT_BITS'(MAX_ITEMS)) begin
         buckets = CNT_BITS'(MAX_ITEMS);
      end else begin
         buckets = CNT_BITS'(count_ff);
      end
   end

   // bucket = floor(buckets * value / 2^VALUE_BITS), clamped to the top bucket
   assign product = PROD_BITS'(buckets) * PROD_BITS'(req_value);
   assign bk_raw  = product[PROD_BITS-1:VALUE_BITS];

   always_comb begin
      if (bk_raw >= buckets) begin
         bk_clamp = buckets - CNT_BITS'(1);
      end else begin
         bk_clamp = bk_raw;
      end
   end

   // hand the classified transaction to the queue
   assign req_stall         = q_status.full;
   assign push              = req_valid && !q_status.full;
   assign push_entry.value  = req_value;
   assign push_entry.bucket = bk_clamp[IDX_BITS-1:0];
   assign push_entry.last   = req_last;

endmodule

/* design/bsu_queue.sv */
// ----------------------------------------------------------------------------
// bsu_queue: short FIFO between front and back
// Register-based, lets the front accept up to Q_DEPTH entries while the back is sorting.
// ----------------------------------------------------------------------------
module bsu_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bsu_pkg::entry_type    push_entry,
   input  logic                  pop,
   output bsu_pkg::entry_type    head_entry,
   output bsu_pkg::q_status_type q_status
);
   import bsu_pkg::*;

   entry_type               mem_ff [Q_DEPTH];
   logic [Q_IDX_BITS-1:0]   wr_ptr_ff;
   logic [Q_IDX_BITS-1:0]   wr_ptr_in;
   logic [Q_IDX_BITS-1:0]   rd_ptr_ff;
   logic [Q_IDX_BITS-1:0]   rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   fill_ff;
   logic [Q_CNT_BITS-1:0]   fill_in;
   logic                    do_push;
   logic                    do_pop;

   assign q_status.full  = (fill_ff == Q_CNT_BITS'(Q_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_entry     = mem_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + Q_IDX_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + Q_IDX_BITS'(1);
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + Q_CNT_BITS'(1);
         2'b01:   fill_in = fill_ff - Q_CNT_BITS'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/bsu_back.sv */
// ----------------------------------------------------------------------------
// bsu_back: item store, minimum selection and result emission
// Loads queued values into the store; on a last mark, repeatedly scans the
// store for the smallest unemitted {bucket, value} key and emits it.
// ----------------------------------------------------------------------------
module bsu_back (
   input  logic                           clock,
   input  logic                           reset,
   input  bsu_pkg::entry_type             head_entry,
   input  bsu_pkg::q_status_type          q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bsu_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   output logic                           rsp_last_out
);
   import bsu_pkg::*;

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [CNT_BITS-1:0]    loaded_ff;
   logic [CNT_BITS-1:0]    loaded_in;
   logic [CNT_BITS-1:0]    total_ff;
   logic [CNT_BITS-1:0]    total_in;
   logic [CNT_BITS-1:0]    out_cnt_ff;
   logic [CNT_BITS-1:0]    out_cnt_in;
   logic [IDX_BITS-1:0]    scan_ff;
   logic [IDX_BITS-1:0]    scan_in;
   logic                   rd_vld_ff;
   logic                   rd_vld_in;
   logic [IDX_BITS-1:0]    rd_idx_ff;
   logic [IDX_BITS-1:0]    rd_idx_in;
   logic                   best_vld_ff;
   logic                   best_vld_in;
   logic [KEY_BITS-1:0]    best_key_ff;
   logic [KEY_BITS-1:0]    best_key_in;
   logic [IDX_BITS-1:0]    best_idx_ff;
   logic [IDX_BITS-1:0]    best_idx_in;
   logic [MAX_ITEMS-1:0]   done_ff;
   logic [MAX_ITEMS-1:0]   done_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff;
   logic [VALUE_BITS-1:0]  rsp_value_in;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;

   logic                   ram_we;
   logic [IDX_BITS-1:0]    ram_waddr;
   logic [KEY_BITS-1:0]    ram_wdata;
   logic [IDX_BITS-1:0]    ram_raddr;
   logic [KEY_BITS-1:0]    ram_rdata;
   logic                   out_free;
   logic                   store_room;
   logic                   final_pick;

   bsu_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign store_room = (loaded_ff < CNT_BITS'(MAX_ITEMS));
   assign final_pick = (out_cnt_ff + CNT_BITS'(1)) == total_ff;
   assign ram_waddr  = loaded_ff[IDX_BITS-1:0];
   assign ram_wdata  = {head_entry.bucket, head_entry.value};
   assign ram_raddr  = scan_ff;

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      total_in     = total_ff;
      out_cnt_in   = out_cnt_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_vld_in  = best_vld_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;

      // keep the smallest unemitted key seen in this scan
      if (rd_vld_ff && !done_ff[rd_idx_ff] &&
          (!best_vld_ff || (ram_rdata < best_key_ff))) begin
         best_vld_in = 1'b1;
         best_key_in = ram_rdata;
         best_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         ST_LOAD: begin
            // store queued values, start the sort on a last mark
            if (!q_status.empty) begin
               pop = 1'b1;
               if (store_room) begin
                  ram_we    = 1'b1;
                  loaded_in = loaded_ff + CNT_BITS'(1);
               end
               if (head_entry.last) begin
                  total_in    = loaded_in;
                  out_cnt_in  = '0;
                  scan_in     = '0;
                  best_vld_in = 1'b0;
                  done_in     = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read one store entry a cycle
            rd_vld_in = 1'b1;
            rd_idx_in = scan_ff;
            if (CNT_BITS'(scan_ff) == total_ff - CNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN: begin
            // let the final read reach the compare
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // move the minimum into the output register
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_value_in          = best_key_ff[VALUE_BITS-1:0];
               rsp_last_in           = final_pick;
               done_in[best_idx_ff]  = 1'b1;
               out_cnt_in            = out_cnt_ff + CNT_BITS'(1);
               if (final_pick) begin
                  loaded_in = '0;
                  state_in  = ST_LOAD;
               end else begin
                  scan_in     = '0;
                  best_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         loaded_ff    <= '0;
         total_ff     <= '0;
         out_cnt_ff   <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         total_ff     <= total_in;
         out_cnt_ff   <= out_cnt_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         best_vld_ff  <= best_vld_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      best_key_ff  <= best_key_in;
      best_idx_ff  <= best_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;

endmodule

/* design/bucket_sort_unit_interval.sv */
// ----------------------------------------------------------------------------
// bucket_sort_unit_interval: bucket sort of Q0.16 fractions
// Loads one value per transaction and emits the set in order on a last mark.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  req     | in        | req_valid/req_stall | req_value[15:0], req_last
//  rsp     | out       | rsp_valid/rsp_stall | rsp_sorted_value[15:0], rsp_last_out
//  csr     | in        | csr_we             | csr_wdata[6:0] (bucket count)
//
//  Loading takes one transaction per cycle through a four-entry queue while
//  the back end is loading; the front stalls while the queue is full. For each
//  result the selection scan reads every store entry once, a drain state lets
//  the last read reach the compare, and the minimum is then emitted.
//  Reset is synchronous; no clearing pass is needed.
//  A stalled result holds in the output register while the next scan runs.
// ----------------------------------------------------------------------------
module bucket_sort_unit_interval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bsu_pkg::CFG_BITS-1:0]   csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bsu_pkg::VALUE_BITS-1:0] req_value,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bsu_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   output logic                           rsp_last_out
);
   import bsu_pkg::*;

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    head_entry;
   logic         push;
   logic         pop;

   // classify incoming transactions
   bsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_value  (req_value),
      .req_last   (req_last),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple front from back
   bsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // store, sort and emit
   bsu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

/* design/bsu_checker.sv */
// ----------------------------------------------------------------------------
// bsu_checker: port-level checks for the bucket sort unit
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module bsu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_last,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bsu_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   input logic                           rsp_last_out
);
   import bsu_pkg::*;

   logic                req_last_acc;
   logic                rsp_acc;
   logic                rsp_last_acc;
   logic [3:0]          pend_ff;
   logic [3:0]          pend_in;
   logic [CNT_BITS-1:0] out_cnt_ff;
   logic [CNT_BITS-1:0] out_cnt_in;

   assign req_last_acc = req_valid && !req_stall && req_last;
   assign rsp_acc      = rsp_valid && !rsp_stall;
   assign rsp_last_acc = rsp_acc && rsp_last_out;

   // track sets awaiting emission and results given in the current set
   always_comb begin
      pend_in    = pend_ff;
      out_cnt_in = out_cnt_ff;
      case ({req_last_acc, rsp_last_acc})
         2'b10:   pend_in = pend_ff + 4'd1;
         2'b01:   pend_in = pend_ff - 4'd1;
         default: pend_in = pend_ff;
      endcase
      if (rsp_last_acc) begin
         out_cnt_in = '0;
      end else if (rsp_acc) begin
         out_cnt_in = out_cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         out_cnt_ff <= '0;
      end else begin
         pend_ff    <= pend_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_last_out))
      else $error("stalled result changed");

   // no result is pending right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // results appear only for a set whose last mark was accepted
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result without a finished set");

   // a set never yields more results than the store holds
   a_set_size: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> out_cnt_ff < CNT_BITS'(MAX_ITEMS))
      else $error("set emitted too many results");

endmodule

bind bucket_sort_unit_interval bsu_checker u_checker (.*);

/* sim/tb_bucket_sort_unit_interval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bucket_sort_unit_interval: self-checking bench for the bucket sort unit
// Loads sets of Q0.16 fractions under random idle and back-pressure, predicts
// the ascending emission of each set and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_bucket_sort_unit_interval;
   import bsu_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 200;
   localparam int RANDOM_ITEMS  = 300;

   // one emitted element as seen on the result channel
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
   } sorted_word_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CFG_BITS-1:0]   csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  req_last  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_sorted_value;
   logic                  rsp_last_out;

   // predictor state
   logic [CFG_BITS-1:0]   bucket_setting = CFG_BITS'(64);
   logic [VALUE_BITS-1:0] held_value  [MAX_ITEMS];
   logic [IDX_BITS-1:0]   held_bucket [MAX_ITEMS];
   int unsigned           bucket_load [MAX_ITEMS];
   int unsigned           held_count  = 0;
   sorted_word_type       expected_sorted[$];

   int unsigned           loaded_items   = 0;
   int unsigned           fail_count     = 0;
   int unsigned           cycle_count    = 0;
   int unsigned           stall_left     = 0;
   bit                    req_gaps_on    = 1'b1;
   bit                    stall_on       = 1'b1;
   logic [VALUE_BITS-1:0] recent_fraction = '0;

   bucket_sort_unit_interval dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      foreach (bucket_load[b]) bucket_load[b] = 0;
   end

   // bucket count in effect: zero acts as one, oversize acts as the store depth
   function automatic int unsigned effective_span();
      if (bucket_setting == 0) return 1;
      if (bucket_setting > MAX_ITEMS) return MAX_ITEMS;
      return 32'(bucket_setting);
   endfunction

   // load one accepted value and, on a last mark, queue the sorted set
   function automatic void predict_sorted_output(input logic [VALUE_BITS-1:0] v,
                                                 input logic l);
      int unsigned           span;
      int unsigned           slot;
      int unsigned           emitted;
      int unsigned           n;
      int unsigned           m;
      logic [VALUE_BITS-1:0] picks[MAX_ITEMS];
      logic [VALUE_BITS-1:0] tmp;
      sorted_word_type       word;
      span = effective_span();
      if (held_count < MAX_ITEMS) begin
         slot = (span * v) >> VALUE_BITS;
         if (slot >= span) slot = span - 1;
         held_value[held_count]  = v;
         held_bucket[held_count] = slot[IDX_BITS-1:0];
         bucket_load[slot]++;
         held_count++;
         loaded_items++;
      end
      if (!l) return;
      emitted = 0;
      for (int b = 0; b < MAX_ITEMS; b++) begin
         if (bucket_load[b] == 0) continue;
         n = 0;
         for (int i = 0; i < held_count; i++) begin
            if (held_bucket[i] == b) begin
               picks[n] = held_value[i];
               n++;
            end
         end
         // repeated minimum selection within the bucket
         for (int i = 0; i < n; i++) begin
            m = i;
            for (int j = i + 1; j < n; j++) begin
               if (picks[j] < picks[m]) m = j;
            end
            tmp      = picks[i];
            picks[i] = picks[m];
            picks[m] = tmp;
         end
         for (int i = 0; i < n; i++) begin
            word.value = picks[i];
            word.last  = (emitted + 1 == held_count);
            expected_sorted.push_back(word);
            emitted++;
         end
      end
      foreach (bucket_load[b]) bucket_load[b] = 0;
      held_count = 0;
   endfunction

   // idle length: mostly short, a few long
   function automatic int unsigned draw_idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // fraction mix: uniform, extremes, bucket boundaries and repeats
   function automatic logic [VALUE_BITS-1:0] draw_fraction();
      int unsigned           span;
      int unsigned           k;
      int unsigned           boundary;
      int unsigned           r;
      logic [VALUE_BITS-1:0] word;
      span = effective_span();
      r    = $urandom_range(0, 99);
      if (r < 60) begin
         word = VALUE_BITS'($urandom_range(0, 16'hFFFF));
      end else if (r < 70) begin
         case ($urandom_range(0, 3))
            0:       word = '0;
            1:       word = '1;
            2:       word = VALUE_BITS'($urandom_range(0, 15));
            default: word = VALUE_BITS'($urandom_range(16'hFFF0, 16'hFFFF));
         endcase
      end else if (r < 85 && span > 1) begin
         k        = $urandom_range(1, span - 1);
         boundary = ((k << VALUE_BITS) + span - 1) / span;
         word     = VALUE_BITS'(boundary - $urandom_range(0, 1));
      end else if (r < 85) begin
         word = VALUE_BITS'($urandom_range(0, 16'hFFFF));
      end else begin
         word = recent_fraction;
      end
      recent_fraction = word;
      return word;
   endfunction

   function automatic logic [CFG_BITS-1:0] draw_bucket_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return CFG_BITS'(1);
      if (r < 20) return CFG_BITS'(64);
      if (r < 25) return '0;
      if (r < 30) return CFG_BITS'($urandom_range(65, 127));
      return CFG_BITS'($urandom_range(1, 64));
   endfunction

   // send one fraction and wait for its transaction
   task automatic send_fraction(input logic [VALUE_BITS-1:0] v, input logic l);
      int unsigned gap;
      gap = (!req_gaps_on || $urandom_range(0, 99) < 60) ? 0 : draw_idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sorted_output(v, l);
   endtask

   // write the bucket count once the unit has gone quiet
   task automatic set_bucket_count(input logic [CFG_BITS-1:0] n);
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we         <= 1'b0;
      bucket_setting  = n;
   endtask

   // reset count of 64: field extremes, boundary neighbors and duplicates
   task automatic test_default_extremes();
      send_fraction(16'h0000, 1'b0);
      send_fraction(16'hFFFF, 1'b0);
      send_fraction(16'h0400, 1'b0);
      send_fraction(16'h03FF, 1'b0);
      send_fraction(16'h8000, 1'b0);
      send_fraction(16'h7FFF, 1'b0);
      send_fraction(16'h03FF, 1'b0);
      send_fraction(16'hFFFF, 1'b1);
   endtask

   // one bucket holds everything, then a set of a single value
   task automatic test_single_bucket();
      set_bucket_count(CFG_BITS'(1));
      send_fraction(16'hC000, 1'b0);
      send_fraction(16'h0001, 1'b0);
      send_fraction(16'hFFFF, 1'b0);
      send_fraction(16'h4000, 1'b1);
      send_fraction(16'h1234, 1'b1);
   endtask

   // zero and oversize bucket counts
   task automatic test_count_out_of_range();
      set_bucket_count('0);
      send_fraction(16'h9000, 1'b0);
      send_fraction(16'h1000, 1'b1);
      set_bucket_count('1);
      send_fraction(16'hFFFF, 1'b0);
      send_fraction(16'h0000, 1'b0);
      send_fraction(16'h0400, 1'b1);
   endtask

   // count changed while a set is loading: values keep their bucket
   task automatic test_count_change_midload();
      set_bucket_count(CFG_BITS'(2));
      send_fraction(16'hF000, 1'b0);
      send_fraction(16'h1000, 1'b0);
      send_fraction(16'h9000, 1'b0);
      set_bucket_count(CFG_BITS'(64));
      send_fraction(16'h0800, 1'b0);
      send_fraction(16'hFFFF, 1'b1);
   endtask

   // a set that fills the store exactly, then one that overruns it
   task automatic test_store_full();
      set_bucket_count(CFG_BITS'($urandom_range(1, 64)));
      for (int i = 1; i <= MAX_ITEMS; i++) send_fraction(draw_fraction(), i == MAX_ITEMS);
      set_bucket_count(CFG_BITS'($urandom_range(1, 64)));
      for (int i = 1; i <= MAX_ITEMS + 4; i++) begin
         send_fraction(draw_fraction(), i == MAX_ITEMS + 4);
      end
   endtask

   // random sets, mostly small, with count changes between and inside sets
   task automatic test_random_sets();
      int unsigned target;
      int unsigned set_size;
      int unsigned split_at;
      int unsigned r;
      target = loaded_items + RANDOM_ITEMS;
      while (loaded_items < target) begin
         req_gaps_on = ($urandom_range(0, 3) != 0);
         stall_on    = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 25) set_bucket_count(draw_bucket_count());
         r = $urandom_range(0, 99);
         if (r < 70)      set_size = $urandom_range(1, 12);
         else if (r < 92) set_size = $urandom_range(13, 40);
         else if (r < 97) set_size = MAX_ITEMS;
         else             set_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
         split_at = 0;
         if (set_size > 1 && $urandom_range(0, 9) == 0) split_at = $urandom_range(1, set_size - 1);
         for (int i = 0; i < set_size; i++) begin
            if (split_at != 0 && i == split_at) set_bucket_count(draw_bucket_count());
            send_fraction(draw_fraction(), i == set_size - 1);
         end
      end
   endtask

   // drive result back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left == 0 && stall_on && $urandom_range(0, 99) < 25)
         stall_left = draw_idle_length();
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left  = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      sorted_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sorted.size() == 0) begin
            $display("%0t: result with none expected: value=%h last=%b",
                     $time, rsp_sorted_value, rsp_last_out);
            fail_count++;
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_sorted_value !== want.value) begin
               $display("%0t: sorted_value expected %h actual %h",
                        $time, want.value, rsp_sorted_value);
               fail_count++;
            end
            if (rsp_last_out !== want.last) begin
               $display("%0t: last_out expected %b actual %b",
                        $time, want.last, rsp_last_out);
               fail_count++;
            end
         end
      end
   end

   // stop a hung run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_sorted.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : run_tests
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_extremes();
      test_single_bucket();
      test_count_out_of_range();
      test_count_change_midload();
      test_store_full();
      test_random_sets();
      req_valid <= 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/bsu_pkg.sv
design/bsu_ram.sv
design/bsu_front.sv
design/bsu_queue.sv
design/bsu_back.sv
design/bucket_sort_unit_interval.sv
design/bsu_checker.sv
sim/tb_bucket_sort_unit_interval.sv
